[rtl/xed_pkg.sv]
// Shared types and constants of the XML entity decoder.
package xed_pkg;

  localparam int CHAR_BITS = 16;
  localparam int ACC_BITS  = 32;
  localparam int NUM_ENT   = 5;
  localparam int ENT_CHARS = 4;

  localparam logic [15:0] CH_AMP  = 16'h0026;
  localparam logic [15:0] CH_SEMI = 16'h003B;
  localparam logic [15:0] CH_HASH = 16'h0023;
  localparam logic [15:0] CH_XL   = 16'h0078;
  localparam logic [15:0] CH_XU   = 16'h0058;
  localparam logic [15:0] CH_0    = 16'h0030;
  localparam logic [15:0] CH_9    = 16'h0039;
  localparam logic [15:0] CH_AL   = 16'h0061;
  localparam logic [15:0] CH_FL   = 16'h0066;
  localparam logic [15:0] CH_AU   = 16'h0041;
  localparam logic [15:0] CH_FU   = 16'h0046;

  // scan modes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_NAME  = 2'd1;
  localparam logic [1:0] MODE_NUM   = 2'd2;
  localparam logic [1:0] MODE_ERR   = 2'd3;

  // lt, gt, amp, quot, apos
  localparam logic [0:NUM_ENT-1][0:ENT_CHARS-1][15:0] ENT_TEXT = {
    {16'h006C, 16'h0074, 16'h0000, 16'h0000},
    {16'h0067, 16'h0074, 16'h0000, 16'h0000},
    {16'h0061, 16'h006D, 16'h0070, 16'h0000},
    {16'h0071, 16'h0075, 16'h006F, 16'h0074},
    {16'h0061, 16'h0070, 16'h006F, 16'h0073}
  };
  localparam logic [0:NUM_ENT-1][2:0] ENT_LEN = {3'd2, 3'd2, 3'd3, 3'd4, 3'd4};
  localparam logic [0:NUM_ENT-1][15:0] ENT_VALUE = {
    16'h003C, 16'h003E, 16'h0026, 16'h0022, 16'h0027
  };

  // classified character handed from front to back
  typedef struct packed {
    logic [15:0]                              chr;
    logic                                     last;
    logic                                     is_amp;
    logic                                     is_semi;
    logic                                     is_hash;
    logic                                     is_x;
    logic                                     is_dec;
    logic                                     is_hexl;
    logic [3:0]                               dval;
    logic [ENT_CHARS-1:0][NUM_ENT-1:0]        hits;
  } cls_t;

endpackage

[rtl/xed_front.sv]
// Front end: classifies each incoming character for the decode stage.
module xed_front (
  input  logic [15:0]  in_char,
  input  logic         in_last_char,
  output xed_pkg::cls_t cls
);
  import xed_pkg::*;

  always_comb begin
    cls         = '0;
    cls.chr     = in_char;
    cls.last    = in_last_char;
    cls.is_amp  = (in_char == CH_AMP);
    cls.is_semi = (in_char == CH_SEMI);
    cls.is_hash = (in_char == CH_HASH);
    cls.is_x    = (in_char == CH_XL) || (in_char == CH_XU);
    cls.is_dec  = (in_char >= CH_0) && (in_char <= CH_9);
    cls.is_hexl = ((in_char >= CH_AL) && (in_char <= CH_FL)) ||
                  ((in_char >= CH_AU) && (in_char <= CH_FU));
    if (cls.is_dec)
      cls.dval = 4'(in_char - CH_0);
    else if (in_char >= CH_AL)
      cls.dval = 4'(in_char - CH_AL + 16'd10);
    else
      cls.dval = 4'(in_char - CH_AU + 16'd10);
    // per-offset match of the character against every named entity
    for (int k = 0; k < ENT_CHARS; k++) begin
      for (int i = 0; i < NUM_ENT; i++) begin
        cls.hits[k][i] = (ENT_TEXT[i][k] == in_char) && (3'(k) < ENT_LEN[i]);
      end
    end
  end

endmodule

[rtl/xed_fifo.sv]
// Two-entry queue of classified characters between front and back.
module xed_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  xed_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output xed_pkg::cls_t pop_data,
  output logic          empty
);
  import xed_pkg::*;

  cls_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/xed_back.sv]
// Back end: entity decode state machine and output register.
module xed_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  input  xed_pkg::cls_t item,
  output logic          item_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_char,
  output logic          out_char_valid,
  output logic          out_parse_error,
  output logic          out_string_end
);
  import xed_pkg::*;

  logic [1:0]          mode_r, mode_nxt;
  logic [2:0]          off_r, off_nxt;
  logic [NUM_ENT-1:0]  match_r, match_nxt;
  logic                hex_r, hex_nxt;
  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic                err_r, err_nxt;

  logic                out_valid_r;
  logic [15:0]         out_char_r, char_nxt;
  logic                cvalid_r, cvalid_nxt;
  logic                perr_r, send_r;

  logic [NUM_ENT-1:0]  hit;
  logic [NUM_ENT-1:0]  step_hits;
  logic [15:0]         hit_value;
  logic                any_hit;
  logic [2:0]          off_inc;
  logic                digit_ok;
  logic [ACC_BITS+3:0] acc_prod;

  assign item_pop        = item_valid && (!out_valid_r || out_ready);
  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_char_valid  = cvalid_r;
  assign out_parse_error = perr_r;
  assign out_string_end  = send_r;

  always_comb begin
    for (int i = 0; i < NUM_ENT; i++) hit[i] = match_r[i] && (ENT_LEN[i] == off_r);
    any_hit   = |hit;
    hit_value = '0;
    for (int i = NUM_ENT - 1; i >= 0; i--) if (hit[i]) hit_value = ENT_VALUE[i];
    step_hits = off_r[2] ? '0 : item.hits[off_r[1:0]];
    off_inc   = (off_r == 3'd7) ? 3'd7 : off_r + 3'd1;
    digit_ok  = item.is_dec || (hex_r && item.is_hexl);
    // x10 as x8 + x2, x16 as a shift; saturate on any carry past 32 bits
    if (hex_r)
      acc_prod = {acc_r, 4'd0} + {32'd0, item.dval};
    else
      acc_prod = {1'b0, acc_r, 3'd0} + {3'd0, acc_r, 1'b0} + {32'd0, item.dval};
  end

  always_comb begin
    mode_nxt   = mode_r;
    off_nxt    = off_r;
    match_nxt  = match_r;
    hex_nxt    = hex_r;
    acc_nxt    = acc_r;
    err_nxt    = err_r;
    cvalid_nxt = 1'b0;
    char_nxt   = '0;
    case (mode_r)
      MODE_PLAIN: begin
        if (item.is_amp) begin
          mode_nxt  = MODE_NAME;
          off_nxt   = 3'd0;
          match_nxt = '1;
        end else begin
          cvalid_nxt = 1'b1;
          char_nxt   = item.chr;
        end
      end
      MODE_NAME: begin
        if (item.is_semi) begin
          if (any_hit) begin
            cvalid_nxt = 1'b1;
            char_nxt   = hit_value;
            mode_nxt   = MODE_PLAIN;
          end else if (off_r >= 3'd2) begin
            mode_nxt = MODE_ERR;
            err_nxt  = 1'b1;
          end else begin
            mode_nxt = MODE_PLAIN;
          end
        end else if (off_r == 3'd0 && item.is_hash) begin
          mode_nxt = MODE_NUM;
          off_nxt  = 3'd0;
          hex_nxt  = 1'b0;
          acc_nxt  = '0;
        end else begin
          match_nxt = match_r & step_hits;
          off_nxt   = off_inc;
        end
      end
      MODE_NUM: begin
        if (off_r == 3'd0 && item.is_x) begin
          hex_nxt = 1'b1;
          off_nxt = 3'd1;
        end else if (item.is_semi) begin
          cvalid_nxt = 1'b1;
          char_nxt   = acc_r[CHAR_BITS-1:0];
          mode_nxt   = MODE_PLAIN;
        end else if (!digit_ok) begin
          mode_nxt = MODE_ERR;
          err_nxt  = 1'b1;
        end else begin
          acc_nxt = (|acc_prod[ACC_BITS+3:ACC_BITS]) ? '1 : acc_prod[ACC_BITS-1:0];
          off_nxt = off_inc;
        end
      end
      default: ;
    endcase
    // unterminated entity at string end
    if (item.last) begin
      if (mode_nxt == MODE_NUM) err_nxt = 1'b1;
      else if (mode_nxt == MODE_NAME && off_nxt >= 3'd2) err_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_PLAIN;
      off_r       <= 3'd0;
      match_r     <= '1;
      hex_r       <= 1'b0;
      acc_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_pop) begin
        out_valid_r <= 1'b1;
        if (item.last) begin
          mode_r  <= MODE_PLAIN;
          off_r   <= 3'd0;
          match_r <= '1;
          hex_r   <= 1'b0;
          acc_r   <= '0;
          err_r   <= 1'b0;
        end else begin
          mode_r  <= mode_nxt;
          off_r   <= off_nxt;
          match_r <= match_nxt;
          hex_r   <= hex_nxt;
          acc_r   <= acc_nxt;
          err_r   <= err_nxt;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      out_char_r <= char_nxt;
      cvalid_r   <= cvalid_nxt;
      perr_r     <= err_nxt;
      send_r     <= item.last;
    end
  end

endmodule

[rtl/xml_entity_decoder_unit.sv]
// Top level of the XML character entity decoder.
// Usage:
//   Input channel (in_valid/in_ready): one 16-bit code unit per request in
//   in_char, with in_last_char set on the final code unit of a string.
//   Output channel (out_valid/out_ready): exactly one result per input
//   request, in order. out_char holds the decoded code unit when
//   out_char_valid is set, else 0. out_parse_error is set once the string
//   held a malformed entity; out_string_end echoes in_last_char, and on that
//   result out_parse_error is the final status of the string.
// Path: each accepted code unit is classified into a two-entry queue, then
//   decoded into the output register, where out_valid marks the result.
// Throughput: one character per cycle while the receiver keeps out_ready
//   high; the decode state machine updates once per character and the
//   output register is refilled as it drains.
// Reset (rst_n low, synchronous): queue emptied, decoder back in plain text
//   mode, no result pending. All decode state also clears after each
//   last character.
// Receiver stall: the output register holds its result, the queue fills,
//   and in_ready drops once both queue entries are taken.
module xml_entity_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_char,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_char,
  output logic        out_char_valid,
  output logic        out_parse_error,
  output logic        out_string_end
);
  import xed_pkg::*;

  cls_t cls, q_data;
  logic q_full, q_empty, q_pop, push;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  xed_front u_front (
    .in_char      (in_char),
    .in_last_char (in_last_char),
    .cls          (cls)
  );

  xed_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  xed_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (!q_empty),
    .item            (q_data),
    .item_pop        (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_char_valid  (out_char_valid),
    .out_parse_error (out_parse_error),
    .out_string_end  (out_string_end)
  );

endmodule
